[src/fpg_pkg.sv]
// Package: shared types and constants for the frame peak gain analyzer.
package fpg_pkg;

  localparam int MAX_CHANNELS = 8;

  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 3;
  localparam int CHN_W    = 4;
  localparam int FLEN_W   = 22;
  localparam int PVAL_W   = 15;
  localparam int GAIN_W   = 24;
  localparam int PEAK_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int DIVD_W   = PVAL_W + FRAC_W;
  localparam int BITC_W   = $clog2(DIVD_W);
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [2:0] REG_CHANS    = 3'd0;
  localparam logic [2:0] REG_FRAME    = 3'd1;
  localparam logic [2:0] REG_COUPLED  = 3'd2;
  localparam logic [2:0] REG_PEAKVAL  = 3'd3;
  localparam logic [2:0] REG_MAXGAIN  = 3'd4;

  localparam logic [CHN_W-1:0]  RST_CHANS   = 4'd2;
  localparam logic [FLEN_W-1:0] RST_FRAME   = 22'd2048;
  localparam logic              RST_COUPLED = 1'b1;
  localparam logic [PVAL_W-1:0] RST_PEAKVAL = 15'd31130;
  localparam logic [GAIN_W-1:0] RST_MAXGAIN = 24'd655360;

  typedef struct packed {
    logic take;
    logic scan_init;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic load_out;
    logic next_ch;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic scan_last;
    logic div_last;
    logic out_taken;
    logic out_last;
  } status_t;

endpackage

[src/fpg_ctrl.sv]
// Controller: sequences sample intake, peak scan, gain division and result transfer.
module fpg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  fpg_pkg::status_t st,
  output fpg_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take = 1'b1;
          if (st.frame_end) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = S_START;
      end
      S_START: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        state_next   = S_WAIT;
      end
      S_WAIT: begin
        if (st.out_taken) begin
          if (st.out_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.next_ch = 1'b1;
            state_next  = S_START;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/fpg_datapath.sv]
// Datapath: channel peaks, sample time counter, serial gain divider and output register.
module fpg_datapath #(
  parameter int MAX_CHANNELS = fpg_pkg::MAX_CHANNELS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fpg_pkg::CHN_W-1:0]     channels_in_use,
  input  logic [fpg_pkg::FLEN_W-1:0]    frame_len,
  input  logic                          coupled,
  input  logic [fpg_pkg::PVAL_W-1:0]    peak_value,
  input  logic [fpg_pkg::GAIN_W-1:0]    max_gain,
  input  logic [fpg_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [fpg_pkg::CH_W-1:0]      in_channel,
  input  fpg_pkg::cmd_t                 cmd,
  output fpg_pkg::status_t              st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpg_pkg::CH_W-1:0]      out_channel,
  output logic [fpg_pkg::GAIN_W-1:0]    out_gain,
  output logic                          out_last
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [fpg_pkg::PEAK_W-1:0]   peak [MAX_CHANNELS];
  logic [fpg_pkg::FLEN_W-1:0]   count;
  logic [fpg_pkg::CH_W-1:0]     ch_idx;
  logic [fpg_pkg::PEAK_W-1:0]   shared;
  logic [fpg_pkg::PEAK_W-1:0]   divisor;
  logic [fpg_pkg::PEAK_W-1:0]   rem;
  logic [fpg_pkg::DIVD_W-1:0]   quot;
  logic [fpg_pkg::BITC_W-1:0]   bit_cnt;
  logic                         zero_peak;

  logic [fpg_pkg::CHN_W-1:0]    n;
  logic [fpg_pkg::CH_W-1:0]     last_ch;
  logic                         in_use;
  logic [fpg_pkg::PEAK_W-1:0]   mag;
  logic [fpg_pkg::CH_W-1:0]     rd_addr;
  logic [fpg_pkg::PEAK_W-1:0]   rd_peak;
  logic [fpg_pkg::PEAK_W-1:0]   sel_peak;
  logic [fpg_pkg::PEAK_W:0]     trial;
  logic                         trial_ok;
  logic [fpg_pkg::GAIN_W-1:0]   gain_val;

  always_comb begin
    if (channels_in_use == '0) begin
      n = fpg_pkg::CHN_W'(1);
    end else if (channels_in_use > fpg_pkg::CHN_W'(MAX_CHANNELS)) begin
      n = fpg_pkg::CHN_W'(MAX_CHANNELS);
    end else begin
      n = channels_in_use;
    end
  end

  assign last_ch = fpg_pkg::CH_W'(n - fpg_pkg::CHN_W'(1));
  assign in_use  = {1'b0, in_channel} < n;
  assign mag     = in_sample[fpg_pkg::SAMPLE_W-1] ? fpg_pkg::PEAK_W'(~in_sample + 1'b1)
                                                  : in_sample;

  assign rd_addr  = cmd.take ? in_channel : ch_idx;
  assign rd_peak  = peak[rd_addr[IW-1:0]];
  assign sel_peak = coupled ? shared : rd_peak;

  assign st.frame_end = in_use && (in_channel == last_ch) &&
                        ({1'b0, count} + 1'b1 >= {1'b0, frame_len});
  assign st.scan_last = ch_idx == last_ch;
  assign st.div_last  = bit_cnt == '0;
  assign st.out_taken = out_valid && out_ready;
  assign st.out_last  = out_last;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) peak[i] <= '0;
    end else if (cmd.take && in_use && mag > rd_peak) begin
      peak[in_channel[IW-1:0]] <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.take && in_use && in_channel == last_ch && !st.frame_end) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_idx <= '0;
    end else if (cmd.scan_init) begin
      ch_idx <= '0;
    end else if (cmd.scan_step) begin
      ch_idx <= st.scan_last ? '0 : ch_idx + 1'b1;
    end else if (cmd.next_ch) begin
      ch_idx <= ch_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      shared <= '0;
    end else if (cmd.scan_step && rd_peak > shared) begin
      shared <= rd_peak;
    end
  end

  // restoring divide, one quotient bit per cycle
  assign trial    = {rem, quot[fpg_pkg::DIVD_W-1]};
  assign trial_ok = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      divisor   <= sel_peak;
      zero_peak <= sel_peak == '0;
      rem       <= '0;
      quot      <= {peak_value, fpg_pkg::FRAC_W'(0)};
      bit_cnt   <= fpg_pkg::BITC_W'(fpg_pkg::DIVD_W - 1);
    end else if (cmd.div_step) begin
      rem     <= trial_ok ? fpg_pkg::PEAK_W'(trial - {1'b0, divisor})
                          : trial[fpg_pkg::PEAK_W-1:0];
      quot    <= {quot[fpg_pkg::DIVD_W-2:0], trial_ok};
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  assign gain_val = (zero_peak || quot > fpg_pkg::DIVD_W'(max_gain))
                    ? max_gain : quot[fpg_pkg::GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_channel <= ch_idx;
      out_gain    <= gain_val;
      out_last    <= ch_idx == last_ch;
    end
  end

  a_gain_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_gain <= max_gain)
    else $error("gain above max_gain");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> count == '0 && peak[0] == '0)
    else $error("frame state not cleared");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    peak[0] <= fpg_pkg::PEAK_W'(16'h8000))
    else $error("peak magnitude out of range");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !out_valid)
    else $error("sample transfer while a gain is pending");

endmodule

[src/frame_peak_gain_analyzer_core.sv]
// Top level: configuration registers, controller and datapath of the frame peak gain analyzer.
//
// Usage:
//   Samples enter on the s_ channel: s_tdata[15:0] = sample (signed Q1.15),
//   s_tuser[2:0] = channel. Gains leave on the m_ channel: m_tdata[23:0] =
//   gain (unsigned Q8.16), m_tuser[2:0] = out_channel, m_tlast = last gain.
//   Registers are written over the APB port at byte address 4*index.
// Sample intake and gain phase:
//   While no frame is closing a sample is taken every cycle (s_tready high).
//   The sample on the highest channel in use that closes a frame starts the
//   gain phase: a peak scan over the channels in use, then per channel a
//   setup state, the divider (one quotient bit per cycle), a load state and
//   a wait with the gain in the output register until it is taken; s_tready
//   is low throughout the gain phase.
// Reset:
//   Registers return to their defaults, peaks and sample time count clear.
// Stall:
//   A gain held by a low m_tready stays in place; the next channel's divide
//   starts only after its transfer.
module frame_peak_gain_analyzer_core #(
  parameter int MAX_CHANNELS = fpg_pkg::MAX_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // sample
  input  logic [2:0]                   s_tuser,   // channel
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // gain
  output logic [2:0]                   m_tuser,   // out_channel
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [fpg_pkg::DATA_W-1:0]   pwdata,
  output logic [fpg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [fpg_pkg::CHN_W-1:0]  channels_in_use;
  logic [fpg_pkg::FLEN_W-1:0] frame_len;
  logic                       coupled;
  logic [fpg_pkg::PVAL_W-1:0] peak_value;
  logic [fpg_pkg::GAIN_W-1:0] max_gain;
  logic [2:0]                 reg_idx;
  logic                       wr_en;
  fpg_pkg::cmd_t              cmd;
  fpg_pkg::status_t           st;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= fpg_pkg::RST_CHANS;
      frame_len       <= fpg_pkg::RST_FRAME;
      coupled         <= fpg_pkg::RST_COUPLED;
      peak_value      <= fpg_pkg::RST_PEAKVAL;
      max_gain        <= fpg_pkg::RST_MAXGAIN;
    end else if (wr_en) begin
      case (reg_idx)
        fpg_pkg::REG_CHANS:   channels_in_use <= pwdata[fpg_pkg::CHN_W-1:0];
        fpg_pkg::REG_FRAME:   frame_len       <= pwdata[fpg_pkg::FLEN_W-1:0];
        fpg_pkg::REG_COUPLED: coupled         <= pwdata[0];
        fpg_pkg::REG_PEAKVAL: peak_value      <= pwdata[fpg_pkg::PVAL_W-1:0];
        fpg_pkg::REG_MAXGAIN: max_gain        <= pwdata[fpg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fpg_pkg::REG_CHANS:   prdata = fpg_pkg::DATA_W'(channels_in_use);
      fpg_pkg::REG_FRAME:   prdata = fpg_pkg::DATA_W'(frame_len);
      fpg_pkg::REG_COUPLED: prdata = fpg_pkg::DATA_W'(coupled);
      fpg_pkg::REG_PEAKVAL: prdata = fpg_pkg::DATA_W'(peak_value);
      fpg_pkg::REG_MAXGAIN: prdata = fpg_pkg::DATA_W'(max_gain);
      default:              prdata = '0;
    endcase
  end

  fpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  fpg_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .channels_in_use (channels_in_use),
    .frame_len       (frame_len),
    .coupled         (coupled),
    .peak_value      (peak_value),
    .max_gain        (max_gain),
    .in_sample       (s_tdata),
    .in_channel      (s_tuser),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_channel     (m_tuser),
    .out_gain        (m_tdata),
    .out_last        (m_tlast)
  );

endmodule

[tb/sv/tb_frame_peak_gain_analyzer_core.sv]
// Testbench: frame peak gain analyzer, stream and register traffic driven, gains checked against a gain predictor.
module tb_frame_peak_gain_analyzer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 20;
  localparam int SAMPLE_GOAL   = 420;
  localparam int SETTLE_CYCLES = 8 + fpg_pkg::MAX_CHANNELS * 34;
  localparam int STALL_LIMIT   = 5000;

  typedef struct {
    logic [fpg_pkg::CH_W-1:0]   ch;
    logic [fpg_pkg::GAIN_W-1:0] gain;
    logic                       last;
  } gain_rec_t;

  logic                         clk      = 1'b0;
  logic                         rst      = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [15:0]                  s_tdata  = '0;
  logic [2:0]                   s_tuser  = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [23:0]                  m_tdata;
  logic [2:0]                   m_tuser;
  logic                         m_tlast;
  logic                         psel     = 1'b0;
  logic                         penable  = 1'b0;
  logic                         pwrite   = 1'b0;
  logic [fpg_pkg::ADDR_W-1:0]   paddr    = '0;
  logic [fpg_pkg::DATA_W-1:0]   pwdata   = '0;
  logic [fpg_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // predicted configuration and state
  logic [fpg_pkg::CHN_W-1:0]    cfg_chans;
  logic [fpg_pkg::FLEN_W-1:0]   cfg_flen;
  logic                         cfg_coupled;
  logic [fpg_pkg::PVAL_W-1:0]   cfg_pval;
  logic [fpg_pkg::GAIN_W-1:0]   cfg_maxg;
  logic [16:0]                  peak_mag [fpg_pkg::MAX_CHANNELS];
  int unsigned                  time_count;
  gain_rec_t                    pending_gains[$];

  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  int samples_used  = 0;
  int gains_checked = 0;
  int mismatches    = 0;
  int phases        = 0;
  int stall_cycles  = 0;

  frame_peak_gain_analyzer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] sample
    .s_tuser  (s_tuser),   // [2:0] channel
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [23:0] gain
    .m_tuser  (m_tuser),   // [2:0] out_channel
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  function automatic void reset_prediction();
    cfg_chans   = fpg_pkg::RST_CHANS;
    cfg_flen    = fpg_pkg::RST_FRAME;
    cfg_coupled = fpg_pkg::RST_COUPLED;
    cfg_pval    = fpg_pkg::RST_PEAKVAL;
    cfg_maxg    = fpg_pkg::RST_MAXGAIN;
    for (int c = 0; c < fpg_pkg::MAX_CHANNELS; c++) peak_mag[c] = '0;
    time_count = 0;
  endfunction

  function automatic int active_chans();
    if (cfg_chans == 0) return 1;
    if (cfg_chans > fpg_pkg::MAX_CHANNELS) return fpg_pkg::MAX_CHANNELS;
    return int'(cfg_chans);
  endfunction

  function automatic logic [31:0] field_mask(input logic [2:0] idx);
    case (idx)
      fpg_pkg::REG_CHANS:   return 32'h0000_000F;
      fpg_pkg::REG_FRAME:   return 32'h003F_FFFF;
      fpg_pkg::REG_COUPLED: return 32'h0000_0001;
      fpg_pkg::REG_PEAKVAL: return 32'h0000_7FFF;
      fpg_pkg::REG_MAXGAIN: return 32'h00FF_FFFF;
      default:              return 32'h0;
    endcase
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      fpg_pkg::REG_CHANS:   cfg_chans   = val[fpg_pkg::CHN_W-1:0];
      fpg_pkg::REG_FRAME:   cfg_flen    = val[fpg_pkg::FLEN_W-1:0];
      fpg_pkg::REG_COUPLED: cfg_coupled = val[0];
      fpg_pkg::REG_PEAKVAL: cfg_pval    = val[fpg_pkg::PVAL_W-1:0];
      fpg_pkg::REG_MAXGAIN: cfg_maxg    = val[fpg_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [fpg_pkg::GAIN_W-1:0] gain_for_peak(input logic [16:0] pk);
    logic [31:0] quot;
    if (pk == '0) return cfg_maxg;
    quot = {1'b0, cfg_pval, 16'h0000} / {15'h0, pk};
    if (quot > {8'h0, cfg_maxg}) quot = {8'h0, cfg_maxg};
    return quot[fpg_pkg::GAIN_W-1:0];
  endfunction

  // returns 1 when the sample lands on a channel in use
  function automatic bit absorb_sample(input logic [15:0] smp, input logic [2:0] ch);
    int          n;
    logic [16:0] mag;
    logic [16:0] shared;
    gain_rec_t   rec;
    n = active_chans();
    if (int'(ch) >= n) return 0;
    mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    if (mag > peak_mag[ch]) peak_mag[ch] = mag;
    if (int'(ch) != n - 1) return 1;
    if (time_count + 1 < cfg_flen) begin
      time_count++;
      return 1;
    end
    shared = '0;
    for (int c = 0; c < n; c++)
      if (peak_mag[c] > shared) shared = peak_mag[c];
    for (int c = 0; c < n; c++) begin
      rec.ch   = 3'(c);
      rec.gain = gain_for_peak(cfg_coupled ? shared : peak_mag[c]);
      rec.last = (c == n - 1);
      pending_gains.insert(pending_gains.size(), rec);
    end
    for (int c = 0; c < fpg_pkg::MAX_CHANNELS; c++) peak_mag[c] = '0;
    time_count = 0;
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_gain();
    gain_rec_t want;
    if (pending_gains.size() == 0) begin
      report_mismatch("gain transfer with nothing pending, channel", m_tuser, -1);
      return;
    end
    want = pending_gains[0];
    pending_gains.delete(0);
    gains_checked++;
    if (m_tuser !== want.ch)   report_mismatch("out_channel", m_tuser, want.ch);
    if (m_tdata !== want.gain) report_mismatch("gain", m_tdata, want.gain);
    if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_gain();
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[%0t] timeout: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [15:0] smp, input logic [2:0] ch);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (absorb_sample(smp, ch)) samples_used++;
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] with_junk(input logic [2:0] idx, input logic [31:0] val);
    if ($urandom_range(0, 3) == 0) return ($urandom() & ~field_mask(idx)) | val;
    return val;
  endfunction

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      1:       return 16'h0000;
      2:       return 16'($urandom_range(0, 255)) ^ {16{1'($urandom_range(0, 1))}};
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic configure_random();
    logic [31:0] v;
    if ($urandom_range(0, 9) < 7) begin
      v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      set_reg(fpg_pkg::REG_CHANS, with_junk(fpg_pkg::REG_CHANS, v));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: v = $urandom_range(0, 4);
        6, 7:             v = 32;
        8:                v = $urandom_range(5, 31);
        default:          v = $urandom_range(64, 32'h3F_FFFF);
      endcase
      set_reg(fpg_pkg::REG_FRAME, with_junk(fpg_pkg::REG_FRAME, v));
    end
    if ($urandom_range(0, 9) < 7)
      set_reg(fpg_pkg::REG_COUPLED, with_junk(fpg_pkg::REG_COUPLED, $urandom_range(0, 1)));
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0:       v = 1;
        1:       v = 32767;
        2:       v = $urandom() & 32'h7FFF;
        default: v = $urandom_range(1, 32767);
      endcase
      set_reg(fpg_pkg::REG_PEAKVAL, with_junk(fpg_pkg::REG_PEAKVAL, v));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0:       v = 65536;
        1:       v = 32'hFF_FFFF;
        2:       v = $urandom() & 32'hFF_FFFF;
        default: v = $urandom_range(65536, 2000000);
      endcase
      set_reg(fpg_pkg::REG_MAXGAIN, with_junk(fpg_pkg::REG_MAXGAIN, v));
    end
  endtask

  // reset configuration, frame cut short by a lower frame_len
  task automatic test_reset_defaults();
    send_sample(16'd1000, 3'd0);
    send_sample(16'(-3000), 3'd1);
    quiesce();
    set_reg(fpg_pkg::REG_FRAME, 1);
    send_sample(16'd0, 3'd1);
  endtask

  task automatic test_gain_extremes();
    quiesce();
    set_reg(fpg_pkg::REG_CHANS, 1);
    set_reg(fpg_pkg::REG_COUPLED, 0);
    set_reg(fpg_pkg::REG_PEAKVAL, 32767);
    set_reg(fpg_pkg::REG_MAXGAIN, 32'hFF_FFFF);
    send_sample(16'h0000, 3'd0);
    send_sample(16'h7FFF, 3'd0);
    send_sample(16'h8000, 3'd0);
    send_sample(16'hFFFF, 3'd0);
    quiesce();
    set_reg(fpg_pkg::REG_PEAKVAL, 1);
    set_reg(fpg_pkg::REG_MAXGAIN, 65536);
    send_sample(16'h0001, 3'd0);
    quiesce();
    set_reg(fpg_pkg::REG_MAXGAIN, 0);
    send_sample(16'h4000, 3'd0);
  endtask

  task automatic test_channel_count_limits();
    quiesce();
    set_reg(fpg_pkg::REG_CHANS, 0);
    set_reg(fpg_pkg::REG_FRAME, 0);
    set_reg(fpg_pkg::REG_PEAKVAL, 20000);
    set_reg(fpg_pkg::REG_MAXGAIN, 32'hFF_FFFF);
    send_sample(16'd1234, 3'd1);
    send_sample(16'(-1234), 3'd0);
    quiesce();
    set_reg(fpg_pkg::REG_CHANS, 15);
    for (int c = 0; c < fpg_pkg::MAX_CHANNELS; c++)
      send_sample(16'(c * 4000 - 14000), 3'(c));
  endtask

  task automatic test_frame_len_lowered();
    quiesce();
    set_reg(fpg_pkg::REG_CHANS, 1);
    set_reg(fpg_pkg::REG_FRAME, 2097152);
    send_sample(16'd300, 3'd0);
    send_sample(16'(-700), 3'd0);
    quiesce();
    set_reg(fpg_pkg::REG_FRAME, 2);
    send_sample(16'd500, 3'd0);
  endtask

  // peak left on a channel dropped mid-frame must not reach the shared peak
  task automatic test_channels_lowered();
    quiesce();
    set_reg(fpg_pkg::REG_CHANS, 4);
    set_reg(fpg_pkg::REG_COUPLED, 1);
    set_reg(fpg_pkg::REG_FRAME, 1);
    send_sample(16'd100, 3'd0);
    send_sample(16'(-200), 3'd1);
    send_sample(16'd30000, 3'd2);
    quiesce();
    set_reg(fpg_pkg::REG_CHANS, 2);
    send_sample(16'd50, 3'd1);
  endtask

  task automatic test_random_frames();
    int n;
    int reps;
    while (samples_used < SAMPLE_GOAL) begin
      phases++;
      src_idle_pct  = (phases >= 6 && phases < 10) ? 0 : IDLE_PCT;
      sink_idle_pct = src_idle_pct;
      quiesce();
      configure_random();
      n    = active_chans();
      reps = $urandom_range(2, 64 / n);
      repeat (reps) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(random_sample(), 3'($urandom_range(0, 7)));
        else
          for (int c = 0; c < n; c++) send_sample(random_sample(), 3'(c));
      end
    end
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  initial begin
    reset_prediction();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_gain_extremes();
    test_channel_count_limits();
    test_frame_len_lowered();
    test_channels_lowered();
    test_random_frames();
    quiesce();
    $display("Run fed %0d in-use samples through %0d random configuration phases.",
             samples_used, phases);
    $display("%0d gains compared, %0d mismatches.", gains_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
